### rtl/core/assert_macros.svh
// Assertion macros used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, switched off while reset is low.
`define BEBBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, switched off while reset is low.
`define BEBBA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked in the next cycle, also during reset.
`define BEBBA_ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bebba_pkg.sv
// Constants, command codes and helper functions of the big-endian byte buffer.
package bebba_pkg;

    localparam int STORE_BYTES = 4096;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int CMP_W       = (ADDR_W + 1 > 16) ? ADDR_W + 1 : 16;

    localparam int CMD_W   = 4;
    localparam int POS_W   = 15;
    localparam int NB_W    = 6;
    localparam int DATA_W  = 64;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 13;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [LEN_W-1:0]   LEN_RESET = 13'd4096;
    localparam logic [NB_W-1:0]    MAX_BITS  = 6'd48;
    localparam logic [PADDR_W-1:0] REG_BUF_LEN_ADDR = 3'd0;

    localparam logic [CMD_W-1:0] CMD_RDU8    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_RDI8    = 4'd1;
    localparam logic [CMD_W-1:0] CMD_RDU16   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_RDI16   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_RDU32   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_RDI32   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_RD32RAW = 4'd6;
    localparam logic [CMD_W-1:0] CMD_RD64    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_WR8     = 4'd8;
    localparam logic [CMD_W-1:0] CMD_WR16    = 4'd9;
    localparam logic [CMD_W-1:0] CMD_WR32    = 4'd10;
    localparam logic [CMD_W-1:0] CMD_WR64    = 4'd11;
    localparam logic [CMD_W-1:0] CMD_RDBITS  = 4'd12;
    localparam logic [CMD_W-1:0] CMD_WRBITS  = 4'd13;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_BITS  = 2'd2;

    // Number of bytes moved by a typed command; zero for the others.
    function automatic logic [3:0] cmd_bytes(input logic [CMD_W-1:0] cmd);
        logic [3:0] n;
        case (cmd)
            CMD_RDU8, CMD_RDI8, CMD_WR8:                    n = 4'd1;
            CMD_RDU16, CMD_RDI16, CMD_WR16:                 n = 4'd2;
            CMD_RDU32, CMD_RDI32, CMD_RD32RAW, CMD_WR32:    n = 4'd4;
            CMD_RD64, CMD_WR64:                             n = 4'd8;
            default:                                        n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic is_typed_write(input logic [CMD_W-1:0] cmd);
        return (cmd == CMD_WR8) || (cmd == CMD_WR16) || (cmd == CMD_WR32) ||
               (cmd == CMD_WR64);
    endfunction

endpackage

### rtl/core/big_endian_byte_buffer_access_core.sv
// Big-endian byte buffer with typed and bit-field access: the top level.
//
// Input channel: i_valid / o_stall carry one command (i_cmd, i_position,
// i_bit_width, i_write_value) per transaction. Output channel: o_valid /
// i_stall carry exactly one result (o_read_data, o_status) per command.
// The buffer_length register sits at APB byte address 0; the user must write
// it only while the block is idle, which the block itself does not enforce.
//
// After reset a clearing pass zeroes the 4096-byte store, one byte per
// cycle, and the block holds o_stall high until it is done. A command
// then runs through a small sequencer around a single byte-wide memory:
// a check, a load of n bytes (n at most 8), a merge, a store of n bytes
// and the posting of the result. A typed read skips the store, a typed
// write skips the load and the merge, a bit-field read skips the store
// and a bit-field write takes every step. Errors and unused commands go
// from the check straight to the posting of the result. A new command
// is taken only once the last result is posted, in the cycle after it;
// if the receiver stalls, the result holds and a following result waits
// until the register frees.
module big_endian_byte_buffer_access_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [bebba_pkg::CMD_W-1:0]      i_cmd,
    input  logic [bebba_pkg::POS_W-1:0]      i_position,
    input  logic [bebba_pkg::NB_W-1:0]       i_bit_width,
    input  logic [bebba_pkg::DATA_W-1:0]     i_write_value,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [bebba_pkg::DATA_W-1:0]     o_read_data,
    output logic [bebba_pkg::STAT_W-1:0]     o_status,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bebba_pkg::PADDR_W-1:0]    paddr,
    input  logic [bebba_pkg::PDATA_W-1:0]    pwdata,
    output logic [bebba_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready
);
    import bebba_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_LOAD,
        S_MERGE,
        S_STORE,
        S_FINISH
    } t_state;

    t_state              r_state;
    logic [CMD_W-1:0]    r_cmd;
    logic [POS_W-1:0]    r_pos;
    logic [NB_W-1:0]     r_nb;
    logic [DATA_W-1:0]   r_wv;
    logic [ADDR_W-1:0]   r_start;
    logic [3:0]          r_n;
    logic [3:0]          r_cnt;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_pend;
    logic [7:0]          r_rdata;
    logic [DATA_W-1:0]   r_data;
    logic [DATA_W-1:0]   r_field;
    logic [2:0]          r_sub;
    logic [DATA_W-1:0]   r_result;
    logic [STAT_W-1:0]   r_status;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_data;
    logic [STAT_W-1:0]   r_out_status;
    logic [LEN_W-1:0]    r_buf_len;
    logic [7:0]          r_mem [STORE_BYTES];

    logic                in_accept;
    logic                cfg_write;
    logic                chk_bits;
    logic [3:0]          chk_size;
    logic [15:0]         chk_sum;
    logic [CMP_W-1:0]    chk_off;
    logic [CMP_W-1:0]    chk_end_b;
    logic [CMP_W-1:0]    chk_end;
    logic [CMP_W-1:0]    chk_len;
    logic [CMP_W-1:0]    chk_nspan;
    logic [3:0]          chk_n;
    logic                chk_ok;
    logic [2:0]          chk_sub;
    logic [DATA_W-1:0]   chk_field;
    logic [DATA_W-1:0]   mrg_mask;
    logic [DATA_W-1:0]   mrg_read;
    logic                mem_we;
    logic                mem_re;
    logic [7:0]          mem_wdata;
    logic                out_free;

    assign o_stall   = (r_state != S_IDLE);
    assign in_accept = i_valid && !o_stall;
    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_status    = r_out_status;
    assign out_free  = !r_out_valid || !i_stall;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_BUF_LEN_ADDR[2]);
    assign prdata    = (paddr[2] == REG_BUF_LEN_ADDR[2]) ? PDATA_W'(r_buf_len) : '0;

    // Range check of the latched command, with its byte span and bit-field mask.
    always_comb begin
        chk_bits  = (r_cmd == CMD_RDBITS) || (r_cmd == CMD_WRBITS);
        chk_size  = cmd_bytes(r_cmd);
        chk_sum   = 16'(r_pos) + 16'(r_nb) + 16'd7;
        chk_off   = chk_bits ? CMP_W'(r_pos[POS_W-1:3]) : CMP_W'(r_pos);
        chk_end_b = CMP_W'(chk_sum[15:3]);
        chk_end   = chk_bits ? chk_end_b : chk_off + CMP_W'(chk_size);
        chk_nspan = chk_end_b - chk_off;
        chk_n     = chk_bits ? chk_nspan[3:0] : chk_size;
        chk_len   = (CMP_W'(r_buf_len) > CMP_W'(STORE_BYTES)) ?
                    CMP_W'(STORE_BYTES) : CMP_W'(r_buf_len);
        chk_ok    = (chk_off < chk_len) && (chk_end <= chk_len);
        chk_sub   = 3'd0 - (r_pos[2:0] + r_nb[2:0]);
        chk_field = (64'd1 << r_nb) - 64'd1;
    end

    // Result of a read once all bytes have been gathered, and the bit-field write mask.
    always_comb begin
        mrg_mask = r_field << r_sub;
        case (r_cmd)
            CMD_RDI8:   mrg_read = {{56{r_data[7]}}, r_data[7:0]};
            CMD_RDI16:  mrg_read = {{48{r_data[15]}}, r_data[15:0]};
            CMD_RDI32:  mrg_read = {{32{r_data[31]}}, r_data[31:0]};
            CMD_RDBITS: mrg_read = (r_data >> r_sub) & r_field;
            default:    mrg_read = r_data;
        endcase
    end

    assign mem_we    = (r_state == S_CLEAR) || ((r_state == S_STORE) && (r_cnt != 4'd0));
    assign mem_re    = (r_state == S_LOAD) && (r_cnt != 4'd0);
    assign mem_wdata = (r_state == S_CLEAR) ? 8'd0 : r_data[7:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_buf_len   <= LEN_RESET;
        end else begin
            if (cfg_write) begin
                r_buf_len <= pwdata[LEN_W-1:0];
            end
            if (r_out_valid && !i_stall && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == ADDR_W'(STORE_BYTES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_cmd   <= i_cmd;
                        r_pos   <= i_position;
                        r_nb    <= i_bit_width;
                        r_wv    <= i_write_value;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_result <= '0;
                    r_status <= ST_OK;
                    r_pend   <= 1'b0;
                    r_start  <= ADDR_W'(chk_off);
                    r_n      <= chk_n;
                    r_cnt    <= chk_n;
                    r_field  <= chk_field;
                    r_sub    <= chk_sub;
                    if (r_cmd > CMD_WRBITS) begin
                        r_state <= S_FINISH;
                    end else if (chk_bits && (r_nb > MAX_BITS)) begin
                        r_status <= ST_BITS;
                        r_state  <= S_FINISH;
                    end else if (!chk_ok) begin
                        r_status <= ST_RANGE;
                        r_state  <= S_FINISH;
                    end else if (is_typed_write(r_cmd)) begin
                        // The last byte holds the least significant byte.
                        r_data  <= r_wv;
                        r_addr  <= ADDR_W'(chk_off) + ADDR_W'(chk_n) - 1'b1;
                        r_state <= S_STORE;
                    end else begin
                        r_data  <= '0;
                        r_addr  <= ADDR_W'(chk_off);
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    // A byte issued in one cycle is shifted in during the next.
                    if (r_cnt != 4'd0) begin
                        r_addr <= r_addr + 1'b1;
                        r_cnt  <= r_cnt - 1'b1;
                    end
                    r_pend <= (r_cnt != 4'd0);
                    if (r_pend) begin
                        r_data <= {r_data[DATA_W-9:0], r_rdata};
                    end
                    if ((r_cnt == 4'd0) && !r_pend) begin
                        r_state <= S_MERGE;
                    end
                end
                S_MERGE: begin
                    if (r_cmd == CMD_WRBITS) begin
                        r_result <= mrg_mask;
                        r_data   <= (r_data & ~mrg_mask) | ((r_wv << r_sub) & mrg_mask);
                        r_addr   <= r_start + ADDR_W'(r_n) - 1'b1;
                        r_cnt    <= r_n;
                        r_state  <= S_STORE;
                    end else begin
                        r_result <= mrg_read;
                        r_state  <= S_FINISH;
                    end
                end
                S_STORE: begin
                    if (r_cnt != 4'd0) begin
                        r_data <= r_data >> 8;
                        r_addr <= r_addr - 1'b1;
                        r_cnt  <= r_cnt - 1'b1;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_data   <= r_result;
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/bebba_checker.sv
// Port-level checker of the byte buffer core and its bind to the top level.
`include "assert_macros.svh"

module bebba_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_stall,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic [bebba_pkg::DATA_W-1:0]     o_read_data,
    input logic [bebba_pkg::STAT_W-1:0]     o_status
);
    import bebba_pkg::*;

    // A result held back by the receiver keeps its value.
    `BEBBA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_read_data) && $stable(o_status), "stalled result changed")

    // Every error result carries zero data.
    `BEBBA_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_valid && (o_status != ST_OK), o_read_data == '0, "error result with non-zero data")

    // Reset leaves no result pending.
    `BEBBA_ASSERT_NXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_valid, "result valid after reset")

    // Once a transaction is taken the block is busy with it.
    `BEBBA_ASSERT_NXT(a_busy_after, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "input not stalled after a transaction")

endmodule

bind big_endian_byte_buffer_access_core bebba_checker u_bebba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_read_data (o_read_data),
    .o_status    (o_status)
);
